FILE: rtl/core/maqi_pkg.sv
// ----------------------------------------------------------------------------
// maqi_pkg
// Shared types and constants for the moving average / quadratic inverse unit.
// ----------------------------------------------------------------------------
package maqi_pkg;

    localparam int COEF_W   = 32;
    localparam int SAMPLE_W = 12;
    localparam int FILL_W   = 31;
    localparam int WSUM_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_C = 2'd2;

    localparam logic [COEF_W-1:0] COEF_A_RST = 32'hFFFF_EB85;  // -5243
    localparam logic [COEF_W-1:0] COEF_B_RST = 32'd906363;
    localparam logic [COEF_W-1:0] COEF_C_RST = 32'd197905039;

    // 30.43 in Q15.16, truncated
    localparam logic [FILL_W-1:0] FILL_MAX_Q = 31'd1994260;
    localparam logic [FILL_W-1:0] FILL_SAT   = 31'h7FFF_FFFF;

    localparam int DET_W  = 68;   // padded to an even bit count
    localparam int ROOT_W = DET_W / 2;
    localparam int SREM_W = ROOT_W + 2;
    localparam int NUM_W  = 36;
    localparam int DVD_W  = 51;   // |num| << 16
    localparam int DVS_W  = 33;   // 2|a|
    localparam int CNT_W  = 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_AVG,
        S_DIFF,
        S_MULA,
        S_MULB,
        S_DET,
        S_SQRT,
        S_QUOT,
        S_DIV,
        S_OUT
    } t_state;

endpackage

FILE: rtl/core/maqi_ram.sv
// ----------------------------------------------------------------------------
// maqi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module maqi_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/moving_average_quadratic_inverse_unit.sv
// ----------------------------------------------------------------------------
// moving_average_quadratic_inverse_unit
// Moving average of force samples, then inversion of a quadratic calibration.
// ----------------------------------------------------------------------------
// One sample beat is taken at a time and yields one result beat, by a shorter
// path when there is no root, a is zero or the quotient would be zero or
// negative; a 34-step bit-pair square root and a 51-step restoring divide set
// the full length, with a shared 32x32 multiplier used in the MULA and MULB
// states. The window lives in a RAM with registered read data; entries count
// as zero until first written. Each result goes to an output register before a
// new sample is taken, and may wait there while the next one is taken. The
// user must write coefficients only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module moving_average_quadratic_inverse_unit #(
    parameter int WINDOW_LEN = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [maqi_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [maqi_pkg::FILL_W-1:0]      o_fill,
    output logic [maqi_pkg::WSUM_W-1:0]      o_window_sum,
    output logic                             o_no_root,
    input  logic                             i_cfg_we,
    input  logic [maqi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [maqi_pkg::COEF_W-1:0]      i_cfg_data
);

    localparam int PTR_W   = $clog2(WINDOW_LEN);
    localparam int SUM_MAX = WINDOW_LEN * 4095;
    localparam int SUM_W   = $clog2(SUM_MAX + 1);
    // average by reciprocal multiply, exact for every reachable sum
    localparam int AVG_SH  = SUM_W + PTR_W;
    localparam int RCP_W   = AVG_SH + 16;
    localparam longint unsigned RCP_L =
        ((64'd1 << RCP_W) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

    maqi_pkg::t_state r_state, n_state;

    logic [maqi_pkg::COEF_W-1:0]   r_coef_a, r_coef_b, r_coef_c;
    logic [WINDOW_LEN-1:0]         r_vld;
    logic [PTR_W-1:0]              r_wpos;
    logic [SUM_W-1:0]              r_sum;
    logic [maqi_pkg::SAMPLE_W-1:0] r_sample;
    logic [31:0]                   r_avg;
    logic signed [33:0]            r_d;
    logic [63:0]                   r_prod, r_p;
    logic                          r_pneg;
    logic [maqi_pkg::DET_W-1:0]    r_det;
    logic [maqi_pkg::SREM_W-1:0]   r_srem;
    logic [maqi_pkg::ROOT_W-1:0]   r_root;
    logic [maqi_pkg::DVD_W-1:0]    r_dvd;
    logic [maqi_pkg::DVS_W-1:0]    r_dvs;
    logic [maqi_pkg::DVS_W-1:0]    r_drem;
    logic [maqi_pkg::CNT_W-1:0]    r_cnt;
    logic [maqi_pkg::FILL_W-1:0]   r_fill;
    logic                          r_noroot;
    logic                          r_out_valid;
    logic [maqi_pkg::FILL_W-1:0]   r_out_fill;
    logic [SUM_W-1:0]              r_out_sum;
    logic                          r_out_noroot;

    logic                          accept;
    logic                          ram_we;
    logic [maqi_pkg::SAMPLE_W-1:0] ram_rdata;
    logic [maqi_pkg::SAMPLE_W-1:0] old_smp;
    logic [SUM_W+RCP_W-1:0]        avg_full;
    logic [31:0]                   mag_a, mag_b, mag_d;
    logic [31:0]                   mul_x, mul_y;
    logic [66:0]                   p4, b2e, det_v;
    logic                          p_gt;
    logic [maqi_pkg::SREM_W+1:0]   s_sh, s_trial;
    logic signed [maqi_pkg::NUM_W-1:0] num;
    logic [maqi_pkg::NUM_W-1:0]    num_mag;
    logic [maqi_pkg::DVS_W:0]      d_sh;
    logic                          out_load;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == maqi_pkg::S_IDLE);
    assign out_load = (r_state == maqi_pkg::S_OUT) && (!r_out_valid || i_ready);

    maqi_ram #(
        .WIDTH (maqi_pkg::SAMPLE_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wpos),
        .i_wdata (r_sample),
        .i_raddr (r_wpos),
        .o_rdata (ram_rdata)
    );

    // datapath helpers
    always_comb begin
        ram_we   = (r_state == maqi_pkg::S_RD);
        old_smp  = r_vld[r_wpos] ? ram_rdata : '0;
        avg_full = r_sum * RCP;
        mag_a    = r_coef_a[31] ? (32'd0 - r_coef_a) : r_coef_a;
        mag_b    = r_coef_b[31] ? (32'd0 - r_coef_b) : r_coef_b;
        mag_d    = r_d[33] ? 32'(34'sd0 - r_d) : r_d[31:0];
        mul_x    = (r_state == maqi_pkg::S_MULA) ? mag_a : mag_b;
        mul_y    = (r_state == maqi_pkg::S_MULA) ? mag_d : mag_b;
        p4       = {1'b0, r_p, 2'b00};
        b2e      = {3'b000, r_prod};
        p_gt     = p4 > b2e;
        det_v    = r_pneg ? (b2e - p4) : (p4 + b2e);
        s_sh     = {r_srem, r_det[maqi_pkg::DET_W-1 -: 2]};
        s_trial  = {2'b00, r_root, 2'b01};
        num      = $signed({2'b00, r_root}) - $signed({{4{r_coef_b[31]}}, r_coef_b});
        num_mag  = num[maqi_pkg::NUM_W-1] ? ('0 - num) : num;
        d_sh     = {r_drem, r_dvd[maqi_pkg::DVD_W-1]};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= maqi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            maqi_pkg::S_IDLE: if (i_valid) n_state = maqi_pkg::S_RD;
            maqi_pkg::S_RD:   n_state = maqi_pkg::S_AVG;
            maqi_pkg::S_AVG:  n_state = maqi_pkg::S_DIFF;
            maqi_pkg::S_DIFF: n_state = maqi_pkg::S_MULA;
            maqi_pkg::S_MULA: n_state = maqi_pkg::S_MULB;
            maqi_pkg::S_MULB: n_state = maqi_pkg::S_DET;
            maqi_pkg::S_DET: begin
                if ((r_pneg && p_gt) || r_coef_a == '0) begin
                    n_state = maqi_pkg::S_OUT;
                end else begin
                    n_state = maqi_pkg::S_SQRT;
                end
            end
            maqi_pkg::S_SQRT: if (r_cnt == '0) n_state = maqi_pkg::S_QUOT;
            maqi_pkg::S_QUOT: begin
                if (num != '0 && num[maqi_pkg::NUM_W-1] == r_coef_a[31]) begin
                    n_state = maqi_pkg::S_DIV;
                end else begin
                    n_state = maqi_pkg::S_OUT;
                end
            end
            maqi_pkg::S_DIV:  if (r_cnt == '0) n_state = maqi_pkg::S_OUT;
            maqi_pkg::S_OUT:  if (!r_out_valid || i_ready) n_state = maqi_pkg::S_IDLE;
            default:          n_state = maqi_pkg::S_IDLE;
        endcase
    end

    // coefficients, ring bookkeeping, output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a    <= maqi_pkg::COEF_A_RST;
            r_coef_b    <= maqi_pkg::COEF_B_RST;
            r_coef_c    <= maqi_pkg::COEF_C_RST;
            r_vld       <= '0;
            r_wpos      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    maqi_pkg::CFG_COEF_A: r_coef_a <= i_cfg_data;
                    maqi_pkg::CFG_COEF_B: r_coef_b <= i_cfg_data;
                    maqi_pkg::CFG_COEF_C: r_coef_c <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == maqi_pkg::S_RD) begin
                r_sum         <= r_sum - SUM_W'(old_smp) + SUM_W'(r_sample);
                r_vld[r_wpos] <= 1'b1;
                r_wpos        <= (r_wpos == PTR_W'(WINDOW_LEN - 1)) ? '0 : r_wpos + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_sample;
        end
        case (r_state)
            maqi_pkg::S_AVG:  r_avg <= 32'(avg_full >> AVG_SH);
            maqi_pkg::S_DIFF: r_d <= $signed({2'b00, r_avg})
                                     - $signed({{2{r_coef_c[31]}}, r_coef_c});
            maqi_pkg::S_MULA: begin
                r_prod <= mul_x * mul_y;
                r_pneg <= (r_coef_a[31] != r_d[33]) && r_coef_a != '0 && r_d != '0;
            end
            maqi_pkg::S_MULB: begin
                r_prod <= mul_x * mul_y;
                r_p    <= r_prod;
            end
            maqi_pkg::S_DET: begin
                r_det    <= {1'b0, det_v};
                r_srem   <= '0;
                r_root   <= '0;
                r_cnt    <= maqi_pkg::CNT_W'(maqi_pkg::ROOT_W - 1);
                r_noroot <= r_pneg && p_gt;
                r_fill   <= (r_pneg && p_gt) ? maqi_pkg::FILL_MAX_Q : '0;
            end
            maqi_pkg::S_SQRT: begin
                r_det <= r_det << 2;
                r_cnt <= r_cnt - 1'b1;
                if (s_sh >= s_trial) begin
                    r_srem <= maqi_pkg::SREM_W'(s_sh - s_trial);
                    r_root <= {r_root[maqi_pkg::ROOT_W-2:0], 1'b1};
                end else begin
                    r_srem <= maqi_pkg::SREM_W'(s_sh);
                    r_root <= {r_root[maqi_pkg::ROOT_W-2:0], 1'b0};
                end
            end
            maqi_pkg::S_QUOT: begin
                r_dvd  <= {num_mag[maqi_pkg::NUM_W-2:0], 16'h0000};
                r_dvs  <= {mag_a, 1'b0};
                r_drem <= '0;
                r_cnt  <= maqi_pkg::CNT_W'(maqi_pkg::DVD_W - 1);
                r_fill <= '0;
            end
            maqi_pkg::S_DIV: begin
                r_cnt <= r_cnt - 1'b1;
                if (d_sh >= {1'b0, r_dvs}) begin
                    r_drem <= maqi_pkg::DVS_W'(d_sh - {1'b0, r_dvs});
                    r_dvd  <= {r_dvd[maqi_pkg::DVD_W-2:0], 1'b1};
                end else begin
                    r_drem <= maqi_pkg::DVS_W'(d_sh);
                    r_dvd  <= {r_dvd[maqi_pkg::DVD_W-2:0], 1'b0};
                end
            end
            maqi_pkg::S_OUT: begin
                if (r_cnt == '0 && r_fill == '0 && !r_noroot && r_dvd != '0) begin
                    r_fill <= '0;
                end
            end
            default: ;
        endcase
        if (out_load) begin
            r_out_sum    <= r_sum;
            r_out_noroot <= r_noroot;
            r_out_fill   <= r_fill;
        end
        if (r_state == maqi_pkg::S_DIV && r_cnt == '0) begin
            r_fill <= (|r_dvd[maqi_pkg::DVD_W-2:maqi_pkg::FILL_W-1])
                      ? maqi_pkg::FILL_SAT
                      : {r_dvd[maqi_pkg::FILL_W-2:0], (d_sh >= {1'b0, r_dvs})};
        end
    end

    assign o_valid      = r_out_valid;
    assign o_fill       = r_out_fill;
    assign o_window_sum = maqi_pkg::WSUM_W'(r_out_sum);
    assign o_no_root    = r_out_noroot;

    a_noroot_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_no_root) |-> (o_fill == maqi_pkg::FILL_MAX_Q))
        else $error("no_root result without maximum fill");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == maqi_pkg::S_RD))
        else $error("accepted sample did not start the ring read");

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum <= SUM_W'(SUM_MAX))
        else $error("window sum out of range");

endmodule

FILE: sim/moving_average_quadratic_inverse_unit_tb.sv
// ----------------------------------------------------------------------------
// moving_average_quadratic_inverse_unit_tb
// Drives force samples through the moving average and quadratic inverse unit
// under random idling on both sides and a long output stall. A scoreboard
// keeps its own window and coefficient copies, works out fill, window sum and
// no-root for every accepted sample beat and checks result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module moving_average_quadratic_inverse_unit_tb;

    import maqi_pkg::*;

    localparam int WIN = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct {
        logic [FILL_W-1:0] fill;
        logic [WSUM_W-1:0] wsum;
        logic              no_root;
    } t_fill_res;

    class fill_scoreboard;
        logic signed [31:0] a, b, c;
        logic [11:0] ring [WIN];
        int unsigned wpos;
        logic [31:0] sum;
        t_fill_res pending[$];
        int errors;
        int checked;
        int no_root_seen;

        function void init();
            foreach (ring[i]) ring[i] = '0;
            wpos = 0;
            sum = 0;
            a = COEF_A_RST;
            b = COEF_B_RST;
            c = COEF_C_RST;
            errors = 0;
            checked = 0;
            no_root_seen = 0;
        endfunction

        function void set_coef(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
            if (idx == CFG_COEF_A) a = v;
            else if (idx == CFG_COEF_B) b = v;
            else if (idx == CFG_COEF_C) c = v;
        endfunction

        function automatic logic [63:0] root_of(logic [127:0] v);
            logic [65:0] rem;
            logic [65:0] trial;
            logic [63:0] r;
            rem = '0;
            r = '0;
            for (int i = 63; i >= 0; i--) begin
                rem = (rem << 2) | v[2*i +: 2];
                trial = {r, 2'b01};
                if (rem >= trial) begin
                    rem = rem - trial;
                    r = {r[62:0], 1'b1};
                end else begin
                    r = {r[62:0], 1'b0};
                end
            end
            return r;
        endfunction

        function void note_sample(logic [11:0] s);
            t_fill_res e;
            logic signed [63:0] avg, d, num, den;
            logic [63:0] ma, md, mb, mn, mdn, q;
            logic [127:0] p4, b2, det;
            bit p_neg;
            sum = sum - ring[wpos] + s;
            ring[wpos] = s;
            wpos = (wpos + 1) % WIN;
            avg = (64'(sum) * 65536) / WIN;
            d = avg - 64'(c);
            ma = a < 0 ? -64'(a) : 64'(a);
            md = d < 0 ? -d : d;
            mb = b < 0 ? -64'(b) : 64'(b);
            p4 = (128'(ma) * 128'(md)) << 2;
            b2 = 128'(mb) * 128'(mb);
            p_neg = ((a < 0) != (d < 0)) && a != 0 && d != 0;
            e.no_root = 1'b0;
            e.fill = '0;
            if (!p_neg) det = p4 + b2;
            else if (p4 > b2) e.no_root = 1'b1;
            else det = b2 - p4;
            if (e.no_root) begin
                e.fill = FILL_MAX_Q;
                no_root_seen++;
            end else if (a != 0) begin
                num = $signed(root_of(det)) - 64'(b);
                den = 2 * 64'(a);
                if (num != 0 && ((num < 0) == (den < 0))) begin
                    mn = num < 0 ? -num : num;
                    mdn = den < 0 ? -den : den;
                    q = (mn * 65536) / mdn;
                    e.fill = q > 64'(FILL_SAT) ? FILL_SAT : q[FILL_W-1:0];
                end
            end
            e.wsum = sum[15:0];
            pending.push_back(e);
        endfunction

        function void check(logic [FILL_W-1:0] f, logic [WSUM_W-1:0] w, logic nr);
            t_fill_res e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat fill=%0d", f);
                return;
            end
            e = pending.pop_front();
            if (f !== e.fill || w !== e.wsum || nr !== e.no_root) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: fill %0d/%0d wsum %0d/%0d no_root %0b/%0b (exp/act)",
                             e.fill, f, e.wsum, w, e.no_root, nr);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic [SAMPLE_W-1:0] i_sample = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic [FILL_W-1:0] o_fill;
    logic [WSUM_W-1:0] o_window_sum;
    logic o_no_root;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COEF_W-1:0] i_cfg_data = '0;

    fill_scoreboard sb;
    int idle_cycles;
    bit stall_out;
    bit sink_no_gaps;

    always #1 i_clk = ~i_clk;

    moving_average_quadratic_inverse_unit #(.WINDOW_LEN(WIN)) u_top (.*);

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(20, 150);
    endfunction

    // valid stays high into the next call; drain() drops it
    task automatic send_sample(logic [11:0] s, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(s);
        @(negedge i_clk);
    endtask

    task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        sb.set_coef(idx, v);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic set_coefs(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        drain();
        write_coef(CFG_COEF_A, a);
        write_coef(CFG_COEF_B, b);
        write_coef(CFG_COEF_C, c);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [11:0] rnd_sample();
        case ($urandom_range(0, 3))
            0: return 12'($urandom_range(0, 4095));
            1: return 12'd4095;
            2: return 12'($urandom_range(0, 15));
            default: return 12'($urandom_range(2000, 3000));
        endcase
    endfunction

    // receiver with random stalls; a long hold-off when asked
    always @(negedge i_clk) begin
        if (stall_out) i_ready <= 1'b0;
        else if (sink_no_gaps) i_ready <= 1'b1;
        else i_ready <= ($urandom_range(0, 9) < 7);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            sb.check(o_fill, o_window_sum, o_no_root);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || stall_out)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("moving_average_quadratic_inverse_unit_tb NOT OK");
            $finish;
        end
    end

    initial begin
        sb = new();
        sb.init();
        idle_cycles = 0;
        stall_out = 1'b0;
        sink_no_gaps = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset coefficients, sample extremes, fill the window
        send_sample(12'd0, 1);
        send_sample(12'd4095, 1);
        for (int i = 0; i < 16; i++) send_sample(12'd4095, 0);
        send_sample(12'd0, 1);
        send_sample(12'hAAA, 1);
        send_sample(12'h555, 1);
        // a zero
        set_coefs(32'd0, 32'd65536, 32'd0);
        send_sample(12'd100, 1);
        // negative det: a>0, c large
        set_coefs(32'd65536, 32'd0, 32'h7FFF_FFFF);
        send_sample(12'd1, 1);
        // saturation: tiny a, huge root
        set_coefs(32'd1, 32'h8000_0000, 32'h8000_0000);
        send_sample(12'd4095, 1);
        // large positive b: root just above b, small positive quotient
        set_coefs(32'd65536, 32'h7FFF_FFFF, 32'd0);
        send_sample(12'd5, 1);
        set_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_sample(12'd4095, 1);
        set_coefs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_sample(12'd0, 1);
        set_coefs(32'hFFFF_FFFF, 32'd0, 32'd0);
        send_sample(12'd2048, 1);

        // pressure: hold off the receiver while samples keep coming
        drain();
        fork
            begin
                stall_out = 1'b1;
                repeat (400) @(negedge i_clk);
                stall_out = 1'b0;
            end
            for (int i = 0; i < 6; i++) send_sample(rnd_sample(), 1);
        join

        // random phases
        for (int ph = 0; ph < 10; ph++) begin
            case (ph % 4)
                0: set_coefs(COEF_A_RST, COEF_B_RST, COEF_C_RST);
                1: set_coefs($urandom, $urandom, $urandom);
                2: set_coefs(32'($signed($urandom_range(0, 200000)) - 100000),
                             $urandom_range(0, 2000000),
                             $urandom_range(0, 300000000));
                default: set_coefs(32'($urandom_range(0, 65535)),
                                   32'(-$signed($urandom_range(0, 1000000))),
                                   32'(-$signed($urandom_range(0, 1000000))));
            endcase
            sink_no_gaps = (ph == 5);
            for (int i = 0; i < 58; i++) send_sample(rnd_sample(), ph == 5);
        end
        sink_no_gaps = 1'b0;
        drain();

        $display("%0d result beats checked over 10 coefficient phases, %0d with no root",
                 sb.checked, sb.no_root_seen);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("moving_average_quadratic_inverse_unit_tb OK");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending.size());
            $display("moving_average_quadratic_inverse_unit_tb NOT OK");
        end
        $finish;
    end

endmodule
